/* hdl/swsu_pkg.sv */
// ----------------------------------------------------------------------------
// swsu_pkg
// Shared widths, codes and control types for the sliding window sender:
// request and timer codes, register indexes, and the command and status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package swsu_pkg;

	// Field widths
	localparam int SEQ_W      = 8;
	localparam int SPACE_W    = 9;
	localparam int WIN_W      = 8;
	localparam int REQ_W      = 2;
	localparam int TMR_W      = 2;
	localparam int DUP_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	// Parameter defaults
	localparam int DEF_MAX_SEQ_SPACE = 256;
	localparam int DEF_PAYLOAD_BITS  = 64;

	// Register reset values
	localparam logic [WIN_W-1:0]   WINDOW_RESET = 8'd4;
	localparam logic [SPACE_W-1:0] SPACE_RESET  = 9'd8;
	localparam logic [SPACE_W-1:0] SPACE_MIN    = 9'd2;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_SEND    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ACK     = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TIMEOUT = 2'd2;

	// Timer commands
	localparam logic [TMR_W-1:0] TMR_NONE    = 2'd0;
	localparam logic [TMR_W-1:0] TMR_START   = 2'd1;
	localparam logic [TMR_W-1:0] TMR_STOP    = 2'd2;
	localparam logic [TMR_W-1:0] TMR_RESTART = 2'd3;

	// Duplicate ACK counter: counts modulo 3, fast retransmit at 2
	localparam logic [DUP_W-1:0] DUP_LAST = 2'd2;
	localparam logic [DUP_W-1:0] DUP_FAST = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACE  = 2'd1;

	// Operand select of the modulo unit
	typedef enum logic [1:0] {
		MOD_SEL_ACK,
		MOD_SEL_BASE,
		MOD_SEL_NEXT
	} mod_sel_t;

	// Controller to datapath
	typedef struct packed {
		logic     capture;
		logic     cfg_we;
		logic     mod_start;
		mod_sel_t mod_sel;
		logic     eval;
		logic     load_base;
		logic     load_next;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic ack_good;
		logic mod_done;
	} dp_stat_t;

endpackage

`default_nettype wire

/* hdl/sliding_window_sender_unit.sv */
// ----------------------------------------------------------------------------
// sliding_window_sender_unit
// Sender side of a windowed reliable transfer with fast retransmit.
// ----------------------------------------------------------------------------
// Send, timeout and corrupt or unknown requests: captured in IDLE and
// evaluated in EVAL; done is registered, the next request taken in IDLE.
// Intact ACK: evaluated once the bit-serial modulo unit (8 steps) is done.
// A seq_space write wraps the pointers via RED_BASE and RED_NEXT, busy high.
// Reset clears pointers, counter and strobe; the store is not cleared.
// Results carry no back-pressure: each is shown for one cycle by done.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_sender_unit #(
	parameter int MAX_SEQ_SPACE = swsu_pkg::DEF_MAX_SEQ_SPACE,
	parameter int PAYLOAD_BITS  = swsu_pkg::DEF_PAYLOAD_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [swsu_pkg::REQ_W-1:0]       req_type,
	input  wire logic [PAYLOAD_BITS-1:0]          payload,
	input  wire logic [swsu_pkg::SEQ_W-1:0]       ack_num,
	input  wire logic                             ack_intact,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [swsu_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [swsu_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                                  done,
	output logic                                  accepted,
	output logic                                  pkt_valid,
	output logic [swsu_pkg::SEQ_W-1:0]            pkt_seq,
	output logic [PAYLOAD_BITS-1:0]               pkt_payload,
	output logic [swsu_pkg::TMR_W-1:0]            timer_cmd,
	output logic [swsu_pkg::SEQ_W-1:0]            window_base,
	output logic [swsu_pkg::SEQ_W-1:0]            next_seq
);

	swsu_pkg::ctrl_cmd_t cmd;
	swsu_pkg::dp_stat_t  stat;

	swsu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.stat      (stat),
		.cmd       (cmd)
	);

	swsu_datapath #(
		.MAX_SEQ_SPACE (MAX_SEQ_SPACE),
		.PAYLOAD_BITS  (PAYLOAD_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_type    (req_type),
		.payload     (payload),
		.ack_num     (ack_num),
		.ack_intact  (ack_intact),
		.done        (done),
		.accepted    (accepted),
		.pkt_valid   (pkt_valid),
		.pkt_seq     (pkt_seq),
		.pkt_payload (pkt_payload),
		.timer_cmd   (timer_cmd),
		.window_base (window_base),
		.next_seq    (next_seq)
	);

endmodule

`default_nettype wire

/* hdl/swsu_mod.sv */
// ----------------------------------------------------------------------------
// swsu_mod
// Restoring remainder unit: reduces an 8-bit value modulo the effective
// sequence space, one operand bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swsu_mod (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [swsu_pkg::SEQ_W-1:0]    operand,
	input  wire logic [swsu_pkg::SPACE_W-1:0]  divisor,
	output logic                               done,
	output logic [swsu_pkg::SEQ_W-1:0]         rem
);

	localparam int CNT_W = $clog2(swsu_pkg::SEQ_W);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [swsu_pkg::SEQ_W-1:0]    x_q;
	logic [swsu_pkg::SEQ_W-1:0]    r_q;
	logic [swsu_pkg::SPACE_W-1:0]  trial;
	logic [swsu_pkg::SEQ_W-1:0]    r_step;

	// Shift in the next operand bit and subtract the divisor when it fits
	always_comb begin
		trial = {r_q, x_q[swsu_pkg::SEQ_W-1]};
		if (trial >= divisor) begin
			r_step = swsu_pkg::SEQ_W'(trial - divisor);
		end else begin
			r_step = swsu_pkg::SEQ_W'(trial);
		end
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(swsu_pkg::SEQ_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Operand and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= operand;
			r_q <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[swsu_pkg::SEQ_W-2:0], 1'b0};
			r_q <= r_step;
		end
	end

	assign done = done_q;
	assign rem  = r_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ({1'b0, r_q} < divisor))
		else $error("remainder not below divisor");

endmodule

`default_nettype wire

/* hdl/swsu_datapath.sv */
// ----------------------------------------------------------------------------
// swsu_datapath
// Window pointers, duplicate counter, configuration registers, packet
// store and result registers. Evaluates one request per eval command.
// ----------------------------------------------------------------------------
`default_nettype none

module swsu_datapath #(
	parameter int MAX_SEQ_SPACE = swsu_pkg::DEF_MAX_SEQ_SPACE,
	parameter int PAYLOAD_BITS  = swsu_pkg::DEF_PAYLOAD_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire swsu_pkg::ctrl_cmd_t              cmd,
	output swsu_pkg::dp_stat_t                    stat,
	input  wire logic [swsu_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [swsu_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic [swsu_pkg::REQ_W-1:0]       req_type,
	input  wire logic [PAYLOAD_BITS-1:0]          payload,
	input  wire logic [swsu_pkg::SEQ_W-1:0]       ack_num,
	input  wire logic                             ack_intact,
	output logic                                  done,
	output logic                                  accepted,
	output logic                                  pkt_valid,
	output logic [swsu_pkg::SEQ_W-1:0]            pkt_seq,
	output logic [PAYLOAD_BITS-1:0]               pkt_payload,
	output logic [swsu_pkg::TMR_W-1:0]            timer_cmd,
	output logic [swsu_pkg::SEQ_W-1:0]            window_base,
	output logic [swsu_pkg::SEQ_W-1:0]            next_seq
);

	localparam int PTR_W = $clog2(MAX_SEQ_SPACE);
	localparam logic [swsu_pkg::SPACE_W-1:0] SPACE_MAX = swsu_pkg::SPACE_W'(MAX_SEQ_SPACE);

	// Configuration and window state
	logic [swsu_pkg::WIN_W-1:0]    window_q;
	logic [swsu_pkg::SPACE_W-1:0]  space_q;
	logic [PTR_W-1:0]              base_q;
	logic [PTR_W-1:0]              next_q;
	logic [swsu_pkg::DUP_W-1:0]    dup_q;

	// Captured request
	logic [swsu_pkg::REQ_W-1:0]    req_q;
	logic                          intact_q;
	logic [PAYLOAD_BITS-1:0]       payload_q;

	// Packet store
	logic [PAYLOAD_BITS-1:0]       store_mem [MAX_SEQ_SPACE];
	logic [PAYLOAD_BITS-1:0]       rd_q;

	// Result registers
	logic                          done_q;
	logic                          accepted_q;
	logic                          pkt_valid_q;
	logic [PTR_W-1:0]              pkt_seq_q;
	logic [PAYLOAD_BITS-1:0]       pkt_payload_q;
	logic [swsu_pkg::TMR_W-1:0]    timer_q;

	// Modulo unit
	logic [swsu_pkg::SEQ_W-1:0]    mod_operand;
	logic [swsu_pkg::SEQ_W-1:0]    mod_rem;
	logic                          mod_done;

	// Window arithmetic
	logic [swsu_pkg::SPACE_W-1:0]  space_eff;
	logic [swsu_pkg::SPACE_W-1:0]  space_m1;
	logic [swsu_pkg::SPACE_W-1:0]  win_eff;
	logic [swsu_pkg::SPACE_W-1:0]  base9;
	logic [swsu_pkg::SPACE_W-1:0]  next9;
	logic [swsu_pkg::SPACE_W-1:0]  rem9;
	logic [swsu_pkg::SPACE_W-1:0]  outst;
	logic [swsu_pkg::SPACE_W-1:0]  ack_gap;
	logic [swsu_pkg::SPACE_W-1:0]  next_inc;
	logic [swsu_pkg::SPACE_W-1:0]  ack_inc;
	logic [swsu_pkg::DUP_W-1:0]    dup_inc;

	// Evaluation results
	logic [PTR_W-1:0]              nx_base;
	logic [PTR_W-1:0]              nx_next;
	logic [swsu_pkg::DUP_W-1:0]    nx_dup;
	logic                          o_acc;
	logic                          o_valid;
	logic [PTR_W-1:0]              o_seq;
	logic [PAYLOAD_BITS-1:0]       o_pay;
	logic [swsu_pkg::TMR_W-1:0]    o_tmr;
	logic                          wr_en;

	// Clamp the sequence space and derive the usable window
	always_comb begin
		if (space_q < swsu_pkg::SPACE_MIN) begin
			space_eff = swsu_pkg::SPACE_MIN;
		end else if (space_q > SPACE_MAX) begin
			space_eff = SPACE_MAX;
		end else begin
			space_eff = space_q;
		end
		space_m1 = space_eff - 1'b1;
		if (swsu_pkg::SPACE_W'(window_q) < space_m1) begin
			win_eff = swsu_pkg::SPACE_W'(window_q);
		end else begin
			win_eff = space_m1;
		end
	end

	// Wrap-aware distances and increments
	always_comb begin
		base9 = swsu_pkg::SPACE_W'(base_q);
		next9 = swsu_pkg::SPACE_W'(next_q);
		rem9  = swsu_pkg::SPACE_W'(mod_rem);
		if (next9 >= base9) begin
			outst = next9 - base9;
		end else begin
			outst = next9 + space_eff - base9;
		end
		if (rem9 >= base9) begin
			ack_gap = rem9 - base9;
		end else begin
			ack_gap = rem9 + space_eff - base9;
		end
		next_inc = (next9 + 1'b1 == space_eff) ? '0 : next9 + 1'b1;
		ack_inc  = (rem9 + 1'b1 == space_eff) ? '0 : rem9 + 1'b1;
		dup_inc  = (dup_q == swsu_pkg::DUP_LAST) ? '0 : dup_q + 1'b1;
	end

	// Evaluate the captured request
	always_comb begin
		nx_base = base_q;
		nx_next = next_q;
		nx_dup  = dup_q;
		o_acc   = 1'b0;
		o_valid = 1'b0;
		o_seq   = '0;
		o_pay   = '0;
		o_tmr   = swsu_pkg::TMR_NONE;
		wr_en   = 1'b0;
		unique case (req_q)
			swsu_pkg::REQ_SEND: begin
				if (outst < win_eff) begin
					wr_en   = 1'b1;
					o_acc   = 1'b1;
					o_valid = 1'b1;
					o_seq   = next_q;
					o_pay   = payload_q;
					if (outst == '0) begin
						o_tmr = swsu_pkg::TMR_START;
					end
					nx_next = PTR_W'(next_inc);
				end
			end
			swsu_pkg::REQ_ACK: begin
				if (intact_q) begin
					if (ack_gap < outst) begin
						// new cumulative ACK: slide the base
						nx_base = PTR_W'(ack_inc);
						o_tmr   = (ack_inc != next9) ? swsu_pkg::TMR_RESTART
							: swsu_pkg::TMR_STOP;
						nx_dup  = '0;
					end else begin
						// duplicate: count it, fast retransmit of the base packet at DUP_FAST
						nx_dup = dup_inc;
						if (dup_inc == swsu_pkg::DUP_FAST && outst != '0) begin
							o_valid = 1'b1;
							o_seq   = base_q;
							o_pay   = rd_q;
						end
					end
				end
			end
			swsu_pkg::REQ_TIMEOUT: begin
				if (outst != '0) begin
					o_valid = 1'b1;
					o_seq   = base_q;
					o_pay   = rd_q;
					o_tmr   = swsu_pkg::TMR_RESTART;
				end
			end
			default: begin
			end
		endcase
	end

	// Pick the operand for the modulo unit
	always_comb begin
		unique case (cmd.mod_sel)
			swsu_pkg::MOD_SEL_ACK:  mod_operand = ack_num;
			swsu_pkg::MOD_SEL_BASE: mod_operand = swsu_pkg::SEQ_W'(base_q);
			swsu_pkg::MOD_SEL_NEXT: mod_operand = swsu_pkg::SEQ_W'(next_q);
			default:                mod_operand = ack_num;
		endcase
	end

	swsu_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mod_start),
		.operand (mod_operand),
		.divisor (space_eff),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	// Configuration registers and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= swsu_pkg::WINDOW_RESET;
			space_q  <= swsu_pkg::SPACE_RESET;
			base_q   <= '0;
			next_q   <= '0;
			dup_q    <= '0;
		end else begin
			if (cmd.cfg_we) begin
				unique case (cfg_index)
					swsu_pkg::CFG_WINDOW: window_q <= cfg_data[swsu_pkg::WIN_W-1:0];
					swsu_pkg::CFG_SPACE:  space_q  <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.eval) begin
				base_q <= nx_base;
				next_q <= nx_next;
				dup_q  <= nx_dup;
			end
			// wrap pointers into a new sequence space
			if (cmd.load_base) begin
				base_q <= PTR_W'(mod_rem);
			end
			if (cmd.load_next) begin
				next_q <= PTR_W'(mod_rem);
			end
		end
	end

	// Capture the request beat
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q     <= req_type;
			intact_q  <= ack_intact;
			payload_q <= payload;
		end
	end

	// Store write at the next sequence number, registered read at the base
	always_ff @(posedge clk) begin
		if (cmd.eval && wr_en) begin
			store_mem[next_q] <= payload_q;
		end
		rd_q <= store_mem[base_q];
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.eval;
		end
	end

	// Result fields
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			accepted_q    <= o_acc;
			pkt_valid_q   <= o_valid;
			pkt_seq_q     <= o_seq;
			pkt_payload_q <= o_pay;
			timer_q       <= o_tmr;
		end
	end

	assign stat.ack_good = (req_type == swsu_pkg::REQ_ACK) && ack_intact;
	assign stat.mod_done = mod_done;

	assign done        = done_q;
	assign accepted    = accepted_q;
	assign pkt_valid   = pkt_valid_q;
	assign pkt_seq     = swsu_pkg::SEQ_W'(pkt_seq_q);
	assign pkt_payload = pkt_payload_q;
	assign timer_cmd   = timer_q;
	assign window_base = swsu_pkg::SEQ_W'(base_q);
	assign next_seq    = swsu_pkg::SEQ_W'(next_q);

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held longer than one cycle");

	a_accept_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && accepted_q) |-> pkt_valid_q)
		else $error("accepted send without emitted packet");

endmodule

`default_nettype wire

/* hdl/swsu_ctrl.sv */
// ----------------------------------------------------------------------------
// swsu_ctrl
// Controller: takes request and configuration beats, sequences the
// modulo unit for ACKs and for pointer wrapping after a space change,
// and issues the evaluate command.
// ----------------------------------------------------------------------------
`default_nettype none

module swsu_ctrl (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [swsu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire swsu_pkg::dp_stat_t              stat,
	output swsu_pkg::ctrl_cmd_t                  cmd
);

	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_EVAL     = 5'b00010,
		ST_MOD_ACK  = 5'b00100,
		ST_RED_BASE = 5'b01000,
		ST_RED_NEXT = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   start_take;
	logic   cfg_take;
	logic   space_wr;

	// Handshakes: a request beat wins over a configuration beat
	assign busy       = (state_q != ST_IDLE);
	assign cfg_ready  = (state_q == ST_IDLE) && !start;
	assign start_take = (state_q == ST_IDLE) && start;
	assign cfg_take   = cfg_valid && cfg_ready;
	assign space_wr   = cfg_take && (cfg_index == swsu_pkg::CFG_SPACE);

	// Next state and commands
	always_comb begin
		state_d           = state_q;
		cmd.capture       = start_take;
		cmd.cfg_we        = cfg_take;
		cmd.mod_start     = 1'b0;
		cmd.mod_sel       = swsu_pkg::MOD_SEL_ACK;
		cmd.eval          = 1'b0;
		cmd.load_base     = 1'b0;
		cmd.load_next     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start_take) begin
					if (stat.ack_good) begin
						cmd.mod_start = 1'b1;
						state_d       = ST_MOD_ACK;
					end else begin
						state_d = ST_EVAL;
					end
				end else if (space_wr) begin
					cmd.mod_start = 1'b1;
					cmd.mod_sel   = swsu_pkg::MOD_SEL_BASE;
					state_d       = ST_RED_BASE;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_MOD_ACK: begin
				if (stat.mod_done) begin
					cmd.eval = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_RED_BASE: begin
				cmd.mod_sel = swsu_pkg::MOD_SEL_NEXT;
				if (stat.mod_done) begin
					cmd.load_base = 1'b1;
					cmd.mod_start = 1'b1;
					state_d       = ST_RED_NEXT;
				end
			end
			ST_RED_NEXT: begin
				if (stat.mod_done) begin
					cmd.load_next = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_hold_for_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOD_ACK && !stat.mod_done) |=> (state_q == ST_MOD_ACK))
		else $error("left ACK wait before remainder was ready");

endmodule

`default_nettype wire
